// ----- hw/rtl/tcpe_pkg.sv -----
package tcpe_pkg;

	localparam int SOCKETS = 2;
	localparam int SW = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;

	localparam logic [5:0] F_FIN = 6'd1;
	localparam logic [5:0] F_SYN = 6'd2;
	localparam logic [5:0] F_RST = 6'd4;
	localparam logic [5:0] F_PSH = 6'd8;
	localparam logic [5:0] F_ACK = 6'd16;
	localparam logic [5:0] F_URG = 6'd32;

	localparam logic [1:0] K_SEG = 2'd0;
	localparam logic [1:0] K_HTTP = 2'd1;
	localparam logic [1:0] K_STAT = 2'd2;

	localparam logic [1:0] S_OK = 2'd0;
	localparam logic [1:0] S_CSUM = 2'd1;
	localparam logic [1:0] S_TXF = 2'd2;

	typedef enum logic [2:0] {
		ST_LISTEN, ST_SYN_RCVD, ST_ESTABLISHED, ST_FIN_WAIT_1, ST_FIN_WAIT_2, ST_LAST_ACK
	} conn_t;

	typedef struct packed {
		logic [31:0] peer_address;
		logic [15:0] peer_port_in;
		logic [15:0] local_port_in;
		logic [31:0] rx_sequence;
		logic [5:0]  rx_flags;
		logic [15:0] payload_length;
		logic        checksum_good;
		logic [31:0] initial_sequence;
		logic        transmit_ok;
		logic        request_complete;
	} seg_in_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [5:0]  tx_flags;
		logic [15:0] tx_local_port;
		logic [15:0] tx_peer_port;
		logic [31:0] tx_peer_address;
		logic [31:0] tx_sequence;
		logic [31:0] tx_acknowledge;
		logic [3:0]  socket_slot;
		logic [1:0]  status_code;
		logic        last_result;
	} res_t;

	typedef struct packed {
		conn_t       st;
		logic [31:0] addr;
		logic [15:0] lport;
		logic [15:0] pport;
		logic [31:0] sseq;
		logic [31:0] ack;
	} sock_t;

endpackage

// ----- hw/rtl/tcp_passive_connection_engine.sv -----
// Sequence: a scan over up to SOCKETS entries (the scan stops at a match), a
// decide step that loads the result queue, then 1 to 3 results, one per cycle
// (bad checksum: a single result in the cycle after acceptance, busy stays low).
// A new segment is taken only while idle; busy drops in the cycle that shows
// the final result (last_result). The socket table is walked one entry per
// cycle through one comparator.
// Reset: all sockets LISTEN with zero fields, server_port 80, block idle.
// Results cannot be stalled by the receiver; each is valid for one cycle.
module tcp_passive_connection_engine import tcpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  seg_in_t     seg,
	output logic        strobe,
	output res_t        result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	typedef enum logic [2:0] {IDLE, SCAN, DECIDE, EMIT} fsm_t;

	fsm_t        state_q;
	seg_in_t     in_q;
	logic [15:0] server_port_q;
	sock_t       tab_q [SOCKETS];
	logic [SW:0] idx_q;
	logic        found_q, listen_q;
	logic [SW-1:0] fidx_q, lidx_q;
	logic [SW-1:0] slot_q;
	res_t        q_q [3];
	logic [1:0]  qn_q, qi_q;
	sock_t       cur;
	logic        hit;

	assign busy = (state_q != IDLE);
	assign cfg_ready = 1'b1;

	// One comparator shared across the scan.
	assign cur = tab_q[idx_q[SW-1:0]];
	assign hit = (cur.addr == in_q.peer_address) && (cur.pport == in_q.peer_port_in)
		&& (cur.lport == in_q.local_port_in);

	function automatic res_t seg_r(logic [5:0] f, logic [15:0] lp, logic [15:0] pp,
			logic [31:0] a, logic [31:0] s, logic [31:0] k, logic [SW-1:0] sl);
		res_t r;
		r = '0;
		r.result_kind = K_SEG;
		r.tx_flags = f;
		r.tx_local_port = lp;
		r.tx_peer_port = pp;
		r.tx_peer_address = a;
		r.tx_sequence = s;
		r.tx_acknowledge = k;
		r.socket_slot = 4'(sl);
		return r;
	endfunction

	// Final status of a segment that failed its checksum.
	function automatic res_t csum_r();
		res_t r;
		r = '0;
		r.result_kind = K_STAT;
		r.status_code = S_CSUM;
		r.last_result = 1'b1;
		return r;
	endfunction

	function automatic sock_t freed(sock_t s);
		sock_t r;
		r = '0;
		r.st = ST_LISTEN;
		r.sseq = s.sseq;
		return r;
	endfunction

	// Intake, scan, decision over the selected socket into the queue, emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			server_port_q <= 16'd80;
			for (int i = 0; i < SOCKETS; i++) begin
				tab_q[i] <= '0;
			end
			strobe <= 1'b0;
			idx_q <= '0;
			found_q <= 1'b0;
			listen_q <= 1'b0;
			qn_q <= '0;
			qi_q <= '0;
		end else begin
			strobe <= 1'b0;
			if (cfg_valid) server_port_q <= cfg_data;
			unique case (state_q)
				IDLE: begin
					if (start) begin
						in_q <= seg;
						idx_q <= '0;
						found_q <= 1'b0;
						listen_q <= 1'b0;
						if (!seg.checksum_good) begin
							result <= csum_r();
							strobe <= 1'b1;
						end else begin
							state_q <= SCAN;
						end
					end
				end
				SCAN: begin
					if (cur.st == ST_LISTEN && !listen_q) begin
						listen_q <= 1'b1;
						lidx_q <= idx_q[SW-1:0];
					end else if (hit) begin
						found_q <= 1'b1;
						fidx_q <= idx_q[SW-1:0];
					end
					if (idx_q == (SW+1)'(SOCKETS - 1) ||
						(hit && !(cur.st == ST_LISTEN && !listen_q)))
						state_q <= DECIDE;
					idx_q <= idx_q + 1'b1;
				end
				DECIDE: begin
					automatic sock_t s;
					automatic logic [SW-1:0] sl;
					automatic logic [1:0] st, n;
					automatic logic tx;
					automatic logic [5:0] f;
					automatic res_t r [3];
					tx = in_q.transmit_ok;
					f = in_q.rx_flags;
					st = S_OK;
					n = 2'd0;
					for (int i = 0; i < 3; i++) r[i] = '0;
					sl = found_q ? fidx_q : (listen_q ? lidx_q : '0);
					s = tab_q[sl];
					if (!found_q && !listen_q) begin
						r[0] = seg_r(F_RST, in_q.local_port_in, in_q.peer_port_in,
							in_q.peer_address, 32'd0, in_q.rx_sequence + 32'd1, '0);
						n = 2'd1;
						st = tx ? S_OK : S_TXF;
					end else if (!found_q) begin
						if ((f & F_SYN) != 0 && in_q.local_port_in == server_port_q) begin
							s.addr = in_q.peer_address;
							s.lport = in_q.local_port_in;
							s.pport = in_q.peer_port_in;
							s.st = ST_SYN_RCVD;
							s.sseq = in_q.initial_sequence;
							s.ack = in_q.rx_sequence + 32'd1;
							r[0] = seg_r(F_SYN | F_ACK, s.lport, s.pport, s.addr, s.sseq,
								s.ack, sl);
							n = 2'd1;
							if (tx) s.sseq = s.sseq + 32'd1;
							else begin
								st = S_TXF;
								s = freed(s);
							end
						end
					end else if ((f & F_SYN) != 0) begin
						r[0] = seg_r(F_RST, in_q.local_port_in, in_q.peer_port_in,
							in_q.peer_address, 32'd0, in_q.rx_sequence + 32'd1, sl);
						n = 2'd1;
						st = tx ? S_OK : S_TXF;
						s = freed(s);
					end else if ((f & F_RST) != 0) begin
						r[0] = seg_r(F_RST, s.lport, s.pport, s.addr, s.sseq, s.ack, sl);
						n = 2'd1;
						st = tx ? S_OK : S_TXF;
						s = freed(s);
					end else if ((f & F_FIN) != 0) begin
						s.ack = in_q.rx_sequence + 32'd1;
						if (s.st == ST_ESTABLISHED) begin
							r[0] = seg_r(F_ACK, s.lport, s.pport, s.addr, s.sseq, s.ack, sl);
							r[1] = seg_r(F_FIN | F_ACK, s.lport, s.pport, s.addr, s.sseq,
								s.ack, sl);
							n = 2'd2;
							if (tx) s.sseq = s.sseq + 32'd1;
							st = tx ? S_OK : S_TXF;
							s.st = ST_LAST_ACK;
						end else if (s.st == ST_FIN_WAIT_1 || s.st == ST_FIN_WAIT_2) begin
							r[0] = seg_r(F_ACK, s.lport, s.pport, s.addr, s.sseq, s.ack, sl);
							n = 2'd1;
							st = tx ? S_OK : S_TXF;
							s = freed(s);
						end
					end else if ((f & F_PSH) != 0) begin
						if (in_q.payload_length != 16'd0) begin
							if (s.st == ST_SYN_RCVD) s.st = ST_ESTABLISHED;
							else if (s.st == ST_ESTABLISHED) begin
								s.ack = in_q.rx_sequence + {16'd0, in_q.payload_length};
								if (s.lport == server_port_q) begin
									r[0] = seg_r(F_ACK, s.lport, s.pport, s.addr, s.sseq,
										s.ack, sl);
									n = 2'd1;
									st = tx ? S_OK : S_TXF;
									if (in_q.request_complete) begin
										r[1].result_kind = K_HTTP;
										r[1].socket_slot = 4'(sl);
										n = 2'd2;
										st = S_OK;
									end
								end else begin
									r[0] = seg_r(F_FIN | F_ACK, s.lport, s.pport, s.addr,
										s.sseq, s.ack, sl);
									n = 2'd1;
									if (tx) s.sseq = s.sseq + 32'd1;
									st = tx ? S_OK : S_TXF;
									s.st = ST_FIN_WAIT_1;
								end
							end
						end
					end else if ((f & F_ACK) != 0) begin
						if (s.st == ST_SYN_RCVD) s.st = ST_ESTABLISHED;
						else if (s.st == ST_ESTABLISHED) begin
							n = 2'd1;
							st = tx ? S_OK : S_TXF;
							if (in_q.payload_length != 16'd0) begin
								r[0] = seg_r(F_ACK, s.lport, s.pport, s.addr, s.sseq,
									s.ack, sl);
							end else begin
								r[0] = seg_r(F_FIN | F_ACK, s.lport, s.pport, s.addr,
									s.sseq, s.ack, sl);
								if (tx) s.sseq = s.sseq + 32'd1;
								s.st = ST_FIN_WAIT_1;
							end
						end else if (s.st == ST_FIN_WAIT_1) s.st = ST_FIN_WAIT_2;
						else if (s.st == ST_LAST_ACK) s = freed(s);
					end
					r[n] = '0;
					r[n].result_kind = K_STAT;
					r[n].socket_slot = 4'(sl);
					r[n].status_code = st;
					r[n].last_result = 1'b1;
					tab_q[sl] <= s;
					for (int i = 0; i < 3; i++) q_q[i] <= r[i];
					qn_q <= n;
					qi_q <= '0;
					state_q <= EMIT;
				end
				EMIT: begin
					result <= q_q[qi_q];
					strobe <= 1'b1;
					qi_q <= qi_q + 2'd1;
					if (qi_q == qn_q) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// A final result always ends the busy period.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_result |-> state_q == IDLE) else $error("last not final");
	a_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SCAN |=> state_q != IDLE) else $error("scan exit");
	a_qn: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == EMIT |-> qi_q <= qn_q) else $error("queue overrun");

endmodule
